### sv/qsd_pkg.sv
// shared constants, types and the dequantisation table of the qoa stream decoder
// no dependencies
package qsd_pkg;

  localparam int CHANNELS = 2;
  localparam int TAPS = 4;
  localparam int SLICE_LEN = 20;
  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [31:0] QOA_MAGIC = 32'h716f6166;
  localparam logic [23:0] RATE_MAX = 24'd65535;

  localparam logic [2:0] PH_FILE   = 3'd0;
  localparam logic [2:0] PH_FRAME  = 3'd1;
  localparam logic [2:0] PH_HIST   = 3'd2;
  localparam logic [2:0] PH_WEIGHT = 3'd3;
  localparam logic [2:0] PH_SLICE  = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC  = 2'd1;
  localparam logic [1:0] ST_BAD_FORMAT = 2'd2;
  localparam logic [1:0] ST_UNSUPP     = 2'd3;

  typedef struct packed {
    logic        start;
    logic [2:0]  ch;
    logic [3:0]  scale;
    logic [59:0] codes;
    logic [4:0]  count;
  } qsd_cmd_t;

  typedef struct packed {
    logic         hist_we;
    logic         wgt_we;
    logic [2:0]   ch;
    logic [63:0]  hist;
    logic [127:0] wgt;
  } qsd_wr_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic [15:0] pcm;
  } qsd_smp_t;

  function automatic logic signed [15:0] dq_lookup(input logic [3:0] sc, input logic [2:0] cd);
    logic signed [15:0] m;
    case (sc)
      4'd0:    m = 16'sd1;
      4'd1:    m = 16'sd5;
      4'd2:    m = 16'sd16;
      4'd3:    m = 16'sd34;
      4'd4:    m = 16'sd63;
      4'd5:    m = 16'sd104;
      4'd6:    m = 16'sd158;
      4'd7:    m = 16'sd228;
      4'd8:    m = 16'sd316;
      4'd9:    m = 16'sd422;
      4'd10:   m = 16'sd548;
      4'd11:   m = 16'sd696;
      4'd12:   m = 16'sd868;
      4'd13:   m = 16'sd1064;
      4'd14:   m = 16'sd1286;
      default: m = 16'sd1536;
    endcase
    case (cd[2:1])
      2'd0: begin
        case (sc)
          default: m = m;
        endcase
      end
      2'd1: begin
        case (sc)
          4'd0:    m = 16'sd3;
          4'd1:    m = 16'sd18;
          4'd2:    m = 16'sd53;
          4'd3:    m = 16'sd113;
          4'd4:    m = 16'sd210;
          4'd5:    m = 16'sd345;
          4'd6:    m = 16'sd528;
          4'd7:    m = 16'sd760;
          4'd8:    m = 16'sd1053;
          4'd9:    m = 16'sd1405;
          4'd10:   m = 16'sd1828;
          4'd11:   m = 16'sd2320;
          4'd12:   m = 16'sd2893;
          4'd13:   m = 16'sd3548;
          4'd14:   m = 16'sd4288;
          default: m = 16'sd5120;
        endcase
      end
      2'd2: begin
        case (sc)
          4'd0:    m = 16'sd5;
          4'd1:    m = 16'sd32;
          4'd2:    m = 16'sd95;
          4'd3:    m = 16'sd203;
          4'd4:    m = 16'sd378;
          4'd5:    m = 16'sd621;
          4'd6:    m = 16'sd950;
          4'd7:    m = 16'sd1368;
          4'd8:    m = 16'sd1895;
          4'd9:    m = 16'sd2529;
          4'd10:   m = 16'sd3290;
          4'd11:   m = 16'sd4176;
          4'd12:   m = 16'sd5207;
          4'd13:   m = 16'sd6386;
          4'd14:   m = 16'sd7718;
          default: m = 16'sd9216;
        endcase
      end
      default: begin
        case (sc)
          4'd0:    m = 16'sd7;
          4'd1:    m = 16'sd49;
          4'd2:    m = 16'sd147;
          4'd3:    m = 16'sd315;
          4'd4:    m = 16'sd588;
          4'd5:    m = 16'sd966;
          4'd6:    m = 16'sd1477;
          4'd7:    m = 16'sd2128;
          4'd8:    m = 16'sd2947;
          4'd9:    m = 16'sd3934;
          4'd10:   m = 16'sd5117;
          4'd11:   m = 16'sd6496;
          4'd12:   m = 16'sd8099;
          4'd13:   m = 16'sd9933;
          4'd14:   m = 16'sd12005;
          default: m = 16'sd14336;
        endcase
      end
    endcase
    return cd[0] ? -m : m;
  endfunction

endpackage

### sv/qoa_stream_decoder.sv
// top level of the qoa stream decoder: header parser, output register
// depends on qsd_pkg and qsd_lms_engine
//
// takes a qoa file as big-endian 64-bit items and returns one result item per header
// word (or per ignored word) and one item per decoded sample of a slice word. for a
// slice word of n samples the channel's lms entry is first read from memory and
// loaded, then each sample takes a multiply step and an accumulate/clamp step, since
// every sample needs the prediction state left by the one before. the channel's
// history and weights are written back to memory with the last sample. no clearing
// pass is needed after reset, as every channel is loaded by the frame header words
// before any slice reads it. items are taken one at a time; the output register is
// free to load again in the cycle its item is taken.
module qoa_stream_decoder
  import qsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // stream_word
  input  logic [0:0]  in_tuser,   // restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // pcm_sample
  output logic [6:0]  out_tuser,  // channel_index[2:0], sample_valid, status[5:4], stream_done
  output logic        out_tlast   // last_of_run
);

  // parse state
  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] left_r, left_nxt;
  logic [15:0] fsamp_r, fsamp_nxt;
  logic [15:0] soff_r, soff_nxt;
  logic [2:0]  chc_r, chc_nxt;
  logic [23:0] rate_r, rate_nxt;
  logic [1:0]  err_r, err_nxt;
  logic        run_r, run_nxt;
  logic [2:0]  smp_ch_r;

  // output register
  logic        ov_r;
  logic [15:0] o_pcm_r;
  logic [2:0]  o_ch_r;
  logic        o_sv_r, o_last_r, o_done_r;
  logic [1:0]  o_st_r;

  logic        out_free, acc, slice_go, single;
  logic [7:0]  nch;
  logic [23:0] rate;
  logic [15:0] fs;
  logic [3:0]  ch_inc;
  logic [15:0] n_rem;
  logic [4:0]  n_cnt;
  logic [16:0] soff_end;
  logic [127:0] wgt_ext;

  qsd_cmd_t cmd;
  qsd_wr_t  wr;
  qsd_smp_t smp;

  assign out_free  = !ov_r || out_tready;
  assign in_tready = !run_r && out_free;
  assign acc       = in_tvalid && in_tready;

  assign nch    = in_tdata[63:56];
  assign rate   = in_tdata[55:32];
  assign fs     = in_tdata[31:16];
  // one bit wider so that a full set of eight channels still compares correctly
  assign ch_inc = {1'b0, chc_r} + 4'd1;
  assign n_rem  = fsamp_r - soff_r;
  assign n_cnt  = (n_rem > 16'(SLICE_LEN)) ? 5'(SLICE_LEN) : n_rem[4:0];
  assign soff_end = {1'b0, soff_r} + 17'(SLICE_LEN);

  // weight word taps are sign-extended to 32 bits
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      wgt_ext[127 - 32 * i -: 32] = {{16{in_tdata[63 - 16 * i]}}, in_tdata[63 - 16 * i -: 16]};
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    fsamp_nxt = fsamp_r;
    soff_nxt  = soff_r;
    chc_nxt   = chc_r;
    rate_nxt  = rate_r;
    err_nxt   = err_r;
    run_nxt   = run_r;
    slice_go  = 1'b0;
    wr        = '0;
    wr.ch     = chc_r;
    wr.hist   = in_tdata;
    wr.wgt    = wgt_ext;
    if (smp.valid && smp.last) run_nxt = 1'b0;
    if (acc) begin
      if (in_tuser[0]) begin
        // restart: back to reset state, then check the file header
        phase_nxt = PH_FILE;
        left_nxt  = '0;
        fsamp_nxt = '0;
        soff_nxt  = '0;
        chc_nxt   = '0;
        rate_nxt  = '0;
        err_nxt   = ST_OK;
        if (in_tdata[63:32] != QOA_MAGIC) begin
          err_nxt = ST_BAD_MAGIC;
        end else if (in_tdata[31:0] == 32'd0) begin
          err_nxt = ST_BAD_FORMAT;
        end else begin
          left_nxt  = in_tdata[31:0];
          phase_nxt = PH_FRAME;
        end
      end else if (err_r != ST_OK || phase_r == PH_FILE || phase_r == PH_DONE) begin
        // word ignored
      end else begin
        case (phase_r)
          PH_FRAME: begin
            if (rate_r == 24'd0) begin
              if (nch == 8'd0 || rate == 24'd0) begin
                err_nxt = ST_BAD_FORMAT;
              end else if (nch != 8'(CHANNELS) || rate > RATE_MAX) begin
                err_nxt = ST_UNSUPP;
              end else begin
                rate_nxt = rate;
              end
            end else if (nch != 8'(CHANNELS) || rate != rate_r) begin
              err_nxt = ST_BAD_FORMAT;
            end
            if (err_nxt == ST_OK) begin
              fsamp_nxt = ({16'd0, fs} < left_r) ? fs : left_r[15:0];
              chc_nxt   = '0;
              phase_nxt = PH_HIST;
            end
          end
          PH_HIST: begin
            wr.hist_we = 1'b1;
            phase_nxt  = PH_WEIGHT;
          end
          PH_WEIGHT: begin
            wr.wgt_we = 1'b1;
            if (ch_inc >= 4'(CHANNELS)) begin
              chc_nxt   = '0;
              soff_nxt  = '0;
              phase_nxt = (fsamp_r == 16'd0) ? PH_FRAME : PH_SLICE;
            end else begin
              chc_nxt   = ch_inc[2:0];
              phase_nxt = PH_HIST;
            end
          end
          PH_SLICE: begin
            slice_go = 1'b1;
            run_nxt  = 1'b1;
            if (ch_inc >= 4'(CHANNELS)) begin
              chc_nxt = '0;
              if (soff_end >= {1'b0, fsamp_r}) begin
                soff_nxt  = '0;
                left_nxt  = left_r - {16'd0, fsamp_r};
                phase_nxt = (left_r == {16'd0, fsamp_r}) ? PH_DONE : PH_FRAME;
              end else begin
                soff_nxt = soff_end[15:0];
              end
            end else begin
              chc_nxt = ch_inc[2:0];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign single = acc && !slice_go;

  assign cmd.start = slice_go;
  assign cmd.ch    = chc_r;
  assign cmd.scale = in_tdata[63:60];
  assign cmd.codes = in_tdata[59:0];
  assign cmd.count = n_cnt;

  qsd_lms_engine u_lms (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr        (wr),
    .smp_ready (out_free),
    .smp       (smp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FILE;
      left_r  <= '0;
      fsamp_r <= '0;
      soff_r  <= '0;
      chc_r   <= '0;
      rate_r  <= '0;
      err_r   <= ST_OK;
      run_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      fsamp_r <= fsamp_nxt;
      soff_r  <= soff_nxt;
      chc_r   <= chc_nxt;
      rate_r  <= rate_nxt;
      err_r   <= err_nxt;
      run_r   <= run_nxt;
      if (single || smp.valid) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // payload: status and done show the state after the word
  always_ff @(posedge clk) begin
    if (slice_go) smp_ch_r <= chc_r;
    if (single) begin
      o_pcm_r  <= '0;
      o_ch_r   <= '0;
      o_sv_r   <= 1'b0;
      o_st_r   <= err_nxt;
      o_last_r <= 1'b1;
      o_done_r <= (phase_nxt == PH_DONE);
    end else if (smp.valid) begin
      o_pcm_r  <= smp.pcm;
      o_ch_r   <= smp_ch_r;
      o_sv_r   <= 1'b1;
      o_st_r   <= err_r;
      o_last_r <= smp.last;
      o_done_r <= (phase_r == PH_DONE);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = o_pcm_r;
  assign out_tuser  = {o_done_r, o_st_r, o_sv_r, o_ch_r};
  assign out_tlast  = o_last_r;

endmodule

### sv/qsd_lms_engine.sv
// per-channel lms state memories and the serial sample reconstruction engine
// depends on qsd_pkg
module qsd_lms_engine
  import qsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  qsd_cmd_t cmd,
  input  qsd_wr_t  wr,
  input  logic     smp_ready,
  output qsd_smp_t smp
);

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_LOAD = 2'd1;
  localparam logic [1:0] E_MUL  = 2'd2;
  localparam logic [1:0] E_ACC  = 2'd3;

  logic [63:0]  hist_mem [CHANNELS];
  logic [127:0] wgt_mem  [CHANNELS];
  logic [63:0]  hist_rd_r;
  logic [127:0] wgt_rd_r;

  logic [1:0]  st_r, st_nxt;
  logic [2:0]  ch_r;
  logic [3:0]  scale_r;
  logic [59:0] codes_r;
  logic [4:0]  cnt_r;

  logic signed [15:0] hist_r [TAPS];
  logic signed [31:0] wgt_r  [TAPS];
  logic signed [47:0] prod_r [TAPS];

  logic signed [15:0] hist_nxt [TAPS];
  logic signed [31:0] wgt_nxt  [TAPS];
  logic [63:0]        hist_pk;
  logic [127:0]       wgt_pk;
  logic signed [49:0] sum;
  logic signed [49:0] v;
  logic signed [15:0] dq, delta, rec;
  logic               fire, last;

  always_comb begin
    dq    = dq_lookup(scale_r, codes_r[59:57]);
    delta = dq >>> 4;
    sum   = '0;
    for (int i = 0; i < TAPS; i++) begin
      sum = sum + 50'(prod_r[i]);
    end
    v = (sum >>> 13) + 50'(dq);
    if (v < -50'sd32768) begin
      rec = -16'sd32768;
    end else if (v > 50'sd32767) begin
      rec = 16'sd32767;
    end else begin
      rec = v[15:0];
    end
    for (int i = 0; i < TAPS; i++) begin
      wgt_nxt[i] = hist_r[i][15] ? wgt_r[i] - 32'(delta) : wgt_r[i] + 32'(delta);
    end
    for (int i = 0; i < TAPS - 1; i++) begin
      hist_nxt[i] = hist_r[i + 1];
    end
    hist_nxt[TAPS - 1] = rec;
    for (int i = 0; i < TAPS; i++) begin
      hist_pk[63 - 16 * i -: 16] = hist_nxt[i];
      wgt_pk[127 - 32 * i -: 32] = wgt_nxt[i];
    end
  end

  assign fire = (st_r == E_ACC) && smp_ready;
  assign last = (cnt_r == 5'd1);

  assign smp.valid = fire;
  assign smp.last  = last;
  assign smp.pcm   = rec;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      E_IDLE: begin
        if (cmd.start) st_nxt = E_LOAD;
      end
      E_LOAD: st_nxt = E_MUL;
      E_MUL:  st_nxt = E_ACC;
      E_ACC: begin
        if (fire) st_nxt = last ? E_IDLE : E_MUL;
      end
      default: st_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= E_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // memories: header writes from the parser, write-back after the last sample
  always_ff @(posedge clk) begin
    if (fire && last) begin
      hist_mem[ch_r[ChIdxW-1:0]] <= hist_pk;
      wgt_mem[ch_r[ChIdxW-1:0]]  <= wgt_pk;
    end else begin
      if (wr.hist_we) hist_mem[wr.ch[ChIdxW-1:0]] <= wr.hist;
      if (wr.wgt_we)  wgt_mem[wr.ch[ChIdxW-1:0]]  <= wr.wgt;
    end
    if (cmd.start) begin
      hist_rd_r <= hist_mem[cmd.ch[ChIdxW-1:0]];
      wgt_rd_r  <= wgt_mem[cmd.ch[ChIdxW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && st_r == E_IDLE) begin
      ch_r    <= cmd.ch;
      scale_r <= cmd.scale;
      codes_r <= cmd.codes;
      cnt_r   <= cmd.count;
    end
    if (st_r == E_LOAD) begin
      for (int i = 0; i < TAPS; i++) begin
        hist_r[i] <= hist_rd_r[63 - 16 * i -: 16];
        wgt_r[i]  <= wgt_rd_r[127 - 32 * i -: 32];
      end
    end
    if (st_r == E_MUL) begin
      for (int i = 0; i < TAPS; i++) begin
        prod_r[i] <= wgt_r[i] * hist_r[i];
      end
    end
    if (fire) begin
      for (int i = 0; i < TAPS; i++) begin
        hist_r[i] <= hist_nxt[i];
        wgt_r[i]  <= wgt_nxt[i];
      end
      codes_r <= {codes_r[56:0], 3'b000};
      cnt_r   <= cnt_r - 5'd1;
    end
  end

endmodule

### sv/qsd_checker.sv
// port-level checks on the qoa stream decoder, bound to the top level
// depends on qoa_stream_decoder
module qsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [6:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("output item changed while stalled");

  // items without a sample carry zero payload
  a_nosample: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[3] |-> out_tdata == 16'd0 && out_tuser[2:0] == 3'd0 && out_tlast)
    else $error("non-sample item with payload");

  // samples are only produced without a latched error
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tuser[5:4] == 2'd0)
    else $error("sample under error status");

  // a restart word gives a single non-sample item next cycle
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> out_tvalid && out_tlast && !out_tuser[3])
    else $error("restart item missing");

endmodule

bind qoa_stream_decoder qsd_checker u_qsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
